// ===== rtl/wsfd_pkg.sv =====
// Shared types and constants of the WebSocket frame deframer.
package wsfd_pkg;

    localparam logic [15:0] MaxPayloadReset = 16'd8096;
    localparam logic [6:0]  LenCodeExt16    = 7'd126;
    localparam logic [6:0]  LenCodeExt64    = 7'd127;
    localparam logic [6:0]  CtrlLenMax      = 7'd125;
    localparam logic [3:0]  OpContinuation  = 4'h0;
    localparam logic [3:0]  OpText          = 4'h1;
    localparam logic [3:0]  OpBinary        = 4'h2;
    localparam logic [3:0]  OpClose         = 4'h8;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_UNMASKED     = 3'd1,
        ST_CONTINUATION = 3'd2,
        ST_CTRL_FRAG    = 3'd3,
        ST_CTRL_LONG    = 3'd4,
        ST_RESERVED     = 3'd5,
        ST_BAD_SIZE     = 3'd6,
        ST_CLOSED       = 3'd7
    } t_status;

    typedef enum logic [8:0] {
        PH_HDR0    = 9'b0_0000_0001,
        PH_HDR1    = 9'b0_0000_0010,
        PH_LENHI   = 9'b0_0000_0100,
        PH_LENLO   = 9'b0_0000_1000,
        PH_KEY0    = 9'b0_0001_0000,
        PH_KEY1    = 9'b0_0010_0000,
        PH_KEY2    = 9'b0_0100_0000,
        PH_KEY3    = 9'b0_1000_0000,
        PH_PAYLOAD = 9'b1_0000_0000
    } t_phase;

    // One input request: a stream byte or a restart.
    typedef struct packed {
        logic       kind;
        logic [7:0] stream_byte;
    } t_item;

    // One result request.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       is_text;
        logic       frame_last;
        t_status    status;
    } t_result;

endpackage

// ===== rtl/wsfd_in_stage.sv =====
// Input register stage of the WebSocket frame deframer.
module wsfd_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  wsfd_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_stall,
    output logic           o_valid,
    output wsfd_pkg::t_item o_item
);
    import wsfd_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The held request leaves only when the result side can take its outcome.
    assign o_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_in_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/wsfd_parser.sv =====
// Frame header parser, unmasking and status generation for the deframer.
module wsfd_parser #(
    parameter int LENGTH_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wsfd_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output logic              o_has_result,
    output wsfd_pkg::t_result o_result
);
    import wsfd_pkg::*;

    localparam logic [15:0] LenLimit = 16'((32'd1 << LENGTH_BITS) - 32'd1);

    t_phase                 r_phase,    n_phase;
    logic [7:0]             r_hdr,      n_hdr;
    logic [7:0]             r_len_hi,   n_len_hi;
    logic [LENGTH_BITS-1:0] r_len,      n_len;
    logic [LENGTH_BITS-1:0] r_count,    n_count;
    logic [31:0]            r_key,      n_key;
    logic                   r_halted,   n_halted;
    logic [15:0]            r_max_payload;

    logic [7:0]  b;
    logic [3:0]  op;
    logic        is_data;
    logic [6:0]  len7;
    logic [15:0] len16;
    logic [7:0]  key_byte;
    logic        last;

    function automatic logic too_big(input logic [15:0] len, input logic [15:0] lim_cfg);
        too_big = (len > lim_cfg) || (len > LenLimit);
    endfunction

    always_comb begin
        b        = i_item.stream_byte;
        op       = r_hdr[3:0];
        is_data  = (op == OpText) || (op == OpBinary);
        len7     = b[6:0];
        len16    = {r_len_hi, b};
        unique case (r_count[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        last     = (r_count + LENGTH_BITS'(1)) >= r_len;

        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_len_hi = r_len_hi;
        n_len    = r_len;
        n_count  = r_count;
        n_key    = r_key;
        n_halted = r_halted;
        o_has_result = 1'b0;
        o_result     = '0;

        if (i_item.kind) begin
            n_phase  = PH_HDR0;
            n_hdr    = '0;
            n_len_hi = '0;
            n_len    = '0;
            n_count  = '0;
            n_key    = '0;
            n_halted = 1'b0;
        end else if (!r_halted) begin
            unique case (r_phase)
                PH_HDR0: begin
                    n_hdr   = b;
                    n_len   = '0;
                    n_key   = '0;
                    n_count = '0;
                    n_phase = PH_HDR1;
                end
                PH_HDR1: begin
                    o_has_result = 1'b1;
                    n_halted     = 1'b1;
                    priority if (!b[7]) begin
                        o_result.status = ST_UNMASKED;
                    end else if (op == OpContinuation) begin
                        o_result.status = ST_CONTINUATION;
                    end else if (!is_data && !r_hdr[7]) begin
                        o_result.status = ST_CTRL_FRAG;
                    end else if (!is_data && len7 > CtrlLenMax) begin
                        o_result.status = ST_CTRL_LONG;
                    end else if (r_hdr[6:4] != 3'b000) begin
                        o_result.status = ST_RESERVED;
                    end else if (len7 == LenCodeExt64) begin
                        o_result.status = ST_BAD_SIZE;
                    end else if (len7 == LenCodeExt16) begin
                        o_has_result = 1'b0;
                        n_halted     = 1'b0;
                        n_phase      = PH_LENHI;
                    end else if (too_big({9'd0, len7}, r_max_payload)) begin
                        o_result.status = ST_BAD_SIZE;
                    end else begin
                        o_has_result = 1'b0;
                        n_halted     = 1'b0;
                        n_len        = LENGTH_BITS'(len7);
                        n_phase      = PH_KEY0;
                    end
                end
                PH_LENHI: begin
                    n_len_hi = b;
                    n_phase  = PH_LENLO;
                end
                PH_LENLO: begin
                    if (len16 < 16'd126 || too_big(len16, r_max_payload)) begin
                        o_has_result    = 1'b1;
                        o_result.status = ST_BAD_SIZE;
                        n_halted        = 1'b1;
                    end else begin
                        n_len   = LENGTH_BITS'(len16);
                        n_phase = PH_KEY0;
                    end
                end
                PH_KEY0: begin
                    n_key   = {r_key[23:0], b};
                    n_phase = PH_KEY1;
                end
                PH_KEY1: begin
                    n_key   = {r_key[23:0], b};
                    n_phase = PH_KEY2;
                end
                PH_KEY2: begin
                    n_key   = {r_key[23:0], b};
                    n_phase = PH_KEY3;
                end
                PH_KEY3: begin
                    // The last key byte decides between payload, an empty-frame marker
                    // and the end of an empty control frame.
                    n_key   = {r_key[23:0], b};
                    n_count = '0;
                    if (r_len != '0) begin
                        n_phase = PH_PAYLOAD;
                    end else if (is_data) begin
                        o_has_result        = 1'b1;
                        o_result.is_text    = (op == OpText);
                        o_result.frame_last = 1'b1;
                        n_phase             = PH_HDR0;
                    end else begin
                        n_phase = PH_HDR0;
                        if (op == OpClose) begin
                            o_has_result    = 1'b1;
                            o_result.status = ST_CLOSED;
                            n_halted        = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_count = r_count + LENGTH_BITS'(1);
                    if (is_data) begin
                        o_has_result        = 1'b1;
                        o_result.payload_byte = b ^ key_byte;
                        o_result.byte_valid = 1'b1;
                        o_result.is_text    = (op == OpText);
                        o_result.frame_last = last;
                        if (last) begin
                            n_phase = PH_HDR0;
                        end
                    end else if (last) begin
                        n_phase = PH_HDR0;
                        if (op == OpClose) begin
                            o_has_result    = 1'b1;
                            o_result.status = ST_CLOSED;
                            n_halted        = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR0;
            r_hdr         <= '0;
            r_len_hi      <= '0;
            r_len         <= '0;
            r_count       <= '0;
            r_key         <= '0;
            r_halted      <= 1'b0;
            r_max_payload <= MaxPayloadReset;
        end else begin
            if (i_fire) begin
                r_phase    <= n_phase;
                r_hdr      <= n_hdr;
                r_len_hi   <= n_len_hi;
                r_len      <= n_len;
                r_count    <= n_count;
                r_key      <= n_key;
                r_halted   <= n_halted;
            end
            if (i_cfg_we) begin
                r_max_payload <= i_cfg_data;
            end
        end
    end

endmodule

// ===== rtl/wsfd_out_stage.sv =====
// Result register stage of the WebSocket frame deframer.
module wsfd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_has_result,
    input  wsfd_pkg::t_result i_result,
    input  logic              i_out_stall,
    output logic              o_advance,
    output logic              o_valid,
    output wsfd_pkg::t_result o_result
);
    import wsfd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // The register can be loaded when it is empty or being drained.
    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire && i_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_fire && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// Top level of the WebSocket client-to-server frame deframer.
//
// Usage: the input channel (i_in_valid / o_in_stall) carries one request per
// byte of the connection stream, or a restart request (i_kind = 1) that
// clears all parsing state for a new connection. The output channel
// (o_out_valid / i_out_stall) carries at most one result request per input:
// an unmasked payload byte of a text or binary frame, the marker of an empty
// data frame, a close status, or an error status. Ping, pong and other
// control payloads give no result.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes max_payload;
// it is always ready and should be written only while the block is idle.
// An accepted byte waits in the input register until the result register can
// take its outcome, and its result is then offered from there. Throughput:
// one byte per cycle while the receiver does not stall, set by the single
// pass of header decode or one XOR between the two registers. Reset
// (synchronous, active low) empties both registers, returns the parser to the
// first header byte and sets max_payload to 8096. When the receiver stalls,
// the result register holds; one more byte may still be accepted into the
// input register, after which o_in_stall rises until the result is taken. After
// an error or a close, bytes are accepted and dropped until a restart arrives.
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [7:0]  i_stream_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_payload_byte,
    output logic        o_byte_valid,
    output logic        o_is_text,
    output logic        o_frame_last,
    output logic [2:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_payload
);
    import wsfd_pkg::*;

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    fire;
    logic    has_result;
    t_result result;
    t_result out_result;

    assign in_item.kind        = i_kind;
    assign in_item.stream_byte = i_stream_byte;

    // A held request is processed when the result register can take it.
    assign fire        = held_valid && advance;
    assign o_cfg_ready = 1'b1;

    wsfd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_item    (in_item),
        .i_advance (advance),
        .o_stall   (o_in_stall),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    wsfd_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (held_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_max_payload),
        .o_has_result(has_result),
        .o_result    (result)
    );

    wsfd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_has_result(has_result),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_valid     (o_out_valid),
        .o_result    (out_result)
    );

    assign o_payload_byte = out_result.payload_byte;
    assign o_byte_valid   = out_result.byte_valid;
    assign o_is_text      = out_result.is_text;
    assign o_frame_last   = out_result.frame_last;
    assign o_status       = out_result.status;

endmodule

// ===== test/websocket_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the WebSocket frame deframer, with a byte-level predictor.
module websocket_frame_deframer_tb;
    import wsfd_pkg::*;

    // The block is built with its widest length field, and the predictor uses the same value.
    localparam int LenBits      = 16;
    // Counted requests per max_payload setting. Six settings give about 1700 in all.
    localparam int PhaseItems   = 285;
    // The receiver holds off this many cycles once, so that the block backs up.
    localparam int LongHold     = 200;
    // Bound on the run length, so that a hung run stops with a failure.
    localparam int CycleLimit   = 400000;
    // Extra wait after the last owed result, to cover a final byte that gives none.
    localparam int SettleCycles = 4;
    localparam int DirectedRows = 27;

    localparam logic       KindByte    = 1'b0;
    localparam logic       KindRestart = 1'b1;
    localparam logic [3:0] OpPing      = 4'h9;

    // These are the states the predictor walks through while it reads one frame.
    typedef enum logic [2:0] {
        AT_HDR0, AT_HDR1, AT_LENHI, AT_LENLO, AT_KEY, AT_BODY
    } t_walk;

    // Each row of the directed table is one input request. When given is set, the row also
    // holds the result that the request must produce. Otherwise the predictor decides.
    typedef struct packed {
        logic    kind;
        logic [7:0] data;
        logic    given;
        t_result want;
    } t_row;

    localparam t_result NoResult = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [7:0]  i_stream_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_payload_byte;
    logic        o_byte_valid;
    logic        o_is_text;
    logic        o_frame_last;
    logic [2:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_max_payload;

    websocket_frame_deframer #(
        .LENGTH_BITS(LenBits)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_stream_byte    (i_stream_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_payload_byte   (o_payload_byte),
        .o_byte_valid     (o_byte_valid),
        .o_is_text        (o_is_text),
        .o_frame_last     (o_frame_last),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_max_payload(i_cfg_max_payload)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // This is the predictor's own copy of the parser state and of the size limit.
    t_walk       ps_walk;
    logic [7:0]  ps_hdr;
    logic [15:0] ps_len;
    logic [31:0] ps_key;
    logic [1:0]  ps_keyn;
    logic [15:0] ps_count;
    bit          ps_halted;
    logic [15:0] cfg_limit;

    // These are the results still owed by the block, oldest first.
    t_result     deframed_q[$];
    t_row        directed_rows[DirectedRows];

    bit          in_calm;
    bit          out_calm;
    bit          hold_off_req;
    int unsigned sent_requests;
    int unsigned useful_requests;
    int unsigned limits_written;
    int unsigned out_draws;
    int unsigned mismatches;
    int unsigned cycles;
    int unsigned seen_bytes;
    int unsigned seen_marks;
    int unsigned seen_closes;
    int unsigned seen_errors;

    task automatic restart_parser();
        ps_walk   = AT_HDR0;
        ps_hdr    = 8'h00;
        ps_len    = 16'd0;
        ps_key    = 32'd0;
        ps_keyn   = 2'd0;
        ps_count  = 16'd0;
        ps_halted = 1'b0;
    endtask

    function automatic bit over_limit(input logic [15:0] n);
        return (n > cfg_limit) || (int'(n) > (1 << LenBits) - 1);
    endfunction

    // This task reads one request into the predictor. It returns the result the block owes
    // for that request, if there is one.
    task automatic deframe_byte(input logic kind, input logic [7:0] b,
                                output bit got, output t_result r);
        logic [3:0] op;
        logic [6:0] code;
        logic [7:0] plain;
        bit         carries_data;
        bit         bad;
        bit         finished;
        bit         last;
        t_status    err;
        got          = 1'b0;
        r            = NoResult;
        bad          = 1'b0;
        finished     = 1'b0;
        err          = ST_OK;
        op           = ps_hdr[3:0];
        code         = b[6:0];
        carries_data = (op == OpText) || (op == OpBinary);
        if (kind == KindRestart) begin
            restart_parser();
        end else if (!ps_halted) begin
            case (ps_walk)
                AT_HDR0: begin
                    ps_hdr   = b;
                    ps_len   = 16'd0;
                    ps_key   = 32'd0;
                    ps_count = 16'd0;
                    ps_walk  = AT_HDR1;
                end
                AT_HDR1: begin
                    // The checks run in priority order. The first one that fires sets the status.
                    bad = 1'b1;
                    if (!b[7]) begin
                        err = ST_UNMASKED;
                    end else if (op == OpContinuation) begin
                        err = ST_CONTINUATION;
                    end else if (!carries_data && !ps_hdr[7]) begin
                        err = ST_CTRL_FRAG;
                    end else if (!carries_data && code > CtrlLenMax) begin
                        err = ST_CTRL_LONG;
                    end else if (ps_hdr[6:4] != 3'b000) begin
                        err = ST_RESERVED;
                    end else if (code == LenCodeExt64) begin
                        err = ST_BAD_SIZE;
                    end else if (code == LenCodeExt16) begin
                        bad     = 1'b0;
                        ps_walk = AT_LENHI;
                    end else if (over_limit({9'd0, code})) begin
                        err = ST_BAD_SIZE;
                    end else begin
                        bad     = 1'b0;
                        ps_len  = {9'd0, code};
                        ps_keyn = 2'd0;
                        ps_walk = AT_KEY;
                    end
                end
                AT_LENHI: begin
                    ps_len  = {b, 8'h00};
                    ps_walk = AT_LENLO;
                end
                AT_LENLO: begin
                    // A 16-bit length must be one that the short form could not hold.
                    ps_len[7:0] = b;
                    if (ps_len < {9'd0, LenCodeExt16} || over_limit(ps_len)) begin
                        bad = 1'b1;
                        err = ST_BAD_SIZE;
                    end else begin
                        ps_keyn = 2'd0;
                        ps_walk = AT_KEY;
                    end
                end
                AT_KEY: begin
                    ps_key = {ps_key[23:0], b};
                    if (ps_keyn == 2'd3) begin
                        ps_count = 16'd0;
                        if (ps_len != 16'd0) begin
                            ps_walk = AT_BODY;
                        end else if (carries_data) begin
                            // An empty data frame still produces one marker result.
                            ps_walk = AT_HDR0;
                            got     = 1'b1;
                            r       = '{8'h00, 1'b0, op == OpText, 1'b1, ST_OK};
                        end else begin
                            finished = 1'b1;
                        end
                    end else begin
                        ps_keyn = ps_keyn + 2'd1;
                    end
                end
                default: begin
                    plain    = b ^ 8'(ps_key >> (24 - 8 * ps_count[1:0]));
                    ps_count = ps_count + 16'd1;
                    last     = ps_count >= ps_len;
                    if (carries_data) begin
                        if (last) begin
                            ps_walk = AT_HDR0;
                        end
                        got = 1'b1;
                        r   = '{plain, 1'b1, op == OpText, last, ST_OK};
                    end else if (last) begin
                        finished = 1'b1;
                    end
                end
            endcase
            // Control payloads are dropped. Only a close frame reports that it has ended.
            if (finished) begin
                ps_walk = AT_HDR0;
                if (op == OpClose) begin
                    ps_halted = 1'b1;
                    got       = 1'b1;
                    r         = '{8'h00, 1'b0, 1'b0, 1'b0, ST_CLOSED};
                end
            end
            if (bad) begin
                ps_halted = 1'b1;
                got       = 1'b1;
                r         = '{8'h00, 1'b0, 1'b0, 1'b0, err};
            end
        end
    endtask

    // This task offers one request after a random gap and holds it until the block takes it.
    // Accepted requests go into the predictor. A directed row with a given result supplies
    // that result in place of the prediction. The task is entered and left at a falling edge.
    task automatic push_request(input logic kind, input logic [7:0] b,
                                input logic given, input t_result want);
        int unsigned gap;
        bit          got;
        t_result     r;
        if (sent_requests % 48 == 0) begin
            in_calm = ($urandom_range(0, 3) == 0);
        end
        gap = in_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= kind;
        i_stream_byte <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        // Bytes that arrive while the block is halted are not counted toward the phase total.
        if (kind == KindRestart || !ps_halted) begin
            useful_requests++;
        end
        sent_requests++;
        deframe_byte(kind, b, got, r);
        if (given) begin
            deframed_q = {deframed_q, want};
        end else if (got) begin
            deframed_q = {deframed_q, r};
        end
        @(negedge i_clk);
    endtask

    // This task drops the input valid and waits until every owed result has been taken. It
    // then waits a little longer, because a final byte may be in flight without producing a
    // result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [15:0] value);
        i_cfg_valid       <= 1'b1;
        i_cfg_max_payload <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        cfg_limit = value;
        limits_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // This task sends one random frame, or a random fragment of one.
    // Most frames are well formed: data frames, control frames and close frames, with random
    // keys and random payloads. Some are deliberately broken, and a few requests are pure noise.
    task automatic random_frame();
        logic [7:0]  fb[$];
        logic [7:0]  hdr;
        logic [3:0]  op;
        logic [15:0] len;
        int          pick;
        int          near;
        int          body;
        int          n;
        bit          end_restart;
        pick        = $urandom_range(0, 99);
        body        = -1;
        len         = 16'd0;
        hdr         = 8'h00;
        end_restart = 1'b0;
        if (pick < 62) begin
            op  = $urandom_range(0, 1) ? OpText : OpBinary;
            hdr = {($urandom_range(0, 4) != 0), 3'b000, op};
            case ($urandom_range(0, 9))
                7: len = 16'($urandom_range(120, 125));
                8: len = 16'($urandom_range(126, 260));
                9: begin
                    // Lengths just around the current limit, or a random extended length when the limit is above 300.
                    near = int'(cfg_limit) + int'($urandom_range(0, 2)) - 1;
                    if (near < 0) begin
                        near = 0;
                    end
                    if (cfg_limit > 16'd300) begin
                        near = $urandom_range(126, 300);
                    end
                    len = near[15:0];
                end
                default: len = 16'($urandom_range(0, 20));
            endcase
            body = len;
        end else if (pick < 76) begin
            // These are ping, pong and reserved opcodes. Their payload is dropped.
            op = 4'($urandom_range(3, 15));
            if (op == OpClose) begin
                op = OpPing;
            end
            hdr  = {($urandom_range(0, 9) != 0), 3'b000, op};
            len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(120, 127))
                                               : 16'($urandom_range(0, 8));
            body = len;
        end else if (pick < 81) begin
            hdr  = {1'b1, 3'b000, OpClose};
            len  = 16'($urandom_range(0, 5));
            body = len;
        end else if (pick < 95) begin
            end_restart = 1'b1;
            case ($urandom_range(0, 3))
                0: begin
                    fb = {fb, 8'($urandom)};
                    fb = {fb, 8'($urandom)};
                    repeat ($urandom_range(0, 8)) fb = {fb, 8'($urandom)};
                end
                1: begin
                    // A 16-bit length that would have fit in the short form.
                    fb = {fb, {1'b1, 3'b000, ($urandom_range(0, 1) ? OpText : OpBinary)}};
                    fb = {fb, {1'b1, LenCodeExt16}};
                    fb = {fb, 8'h00};
                    fb = {fb, 8'($urandom_range(0, 125))};
                    repeat (6) fb = {fb, 8'($urandom)};
                end
                2: begin
                    // The largest length. Only a few payload bytes are sent before the restart.
                    fb = {fb, {1'b1, 3'b000, OpBinary}};
                    fb = {fb, {1'b1, LenCodeExt16}};
                    fb = {fb, 8'hFF};
                    fb = {fb, 8'hFF};
                    repeat ($urandom_range(4, 16)) fb = {fb, 8'($urandom)};
                end
                default: begin
                    fb = {fb, {1'b1, 3'b000, OpBinary}};
                    fb = {fb, {1'b1, LenCodeExt64}};
                    repeat ($urandom_range(0, 3)) fb = {fb, 8'($urandom)};
                end
            endcase
        end else begin
            push_request(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, NoResult);
        end

        if (body >= 0) begin
            fb = {fb, hdr};
            if (len < {9'd0, LenCodeExt16}) begin
                fb = {fb, {1'b1, len[6:0]}};
            end else begin
                fb = {fb, {1'b1, LenCodeExt16}};
                fb = {fb, len[15:8]};
                fb = {fb, len[7:0]};
            end
            repeat (4) fb = {fb, 8'($urandom)};
            repeat (body) fb = {fb, 8'($urandom)};
        end

        n = fb.size();
        // Now and then a frame is cut short and the connection is restarted in the middle of it.
        if (n > 2 && $urandom_range(0, 19) == 0) begin
            n           = $urandom_range(1, n - 1);
            end_restart = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            if (ps_halted) begin
                break;
            end
            push_request(KindByte, fb[i], 1'b0, NoResult);
        end
        // A halted block must drop stray bytes until a restart request arrives.
        if (ps_halted) begin
            repeat ($urandom_range(0, 2)) push_request(KindByte, 8'($urandom), 1'b0, NoResult);
        end
        if (ps_halted || end_restart) begin
            push_request(KindRestart, 8'($urandom), 1'b0, NoResult);
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, seen);
            mismatches++;
        end
    endtask

    // Each result the block hands over is compared with the oldest result still owed.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (deframed_q.size() == 0) begin
                $display("%0t ns: result while none owed, expected none, got %02h %0b %0b %0b %0d",
                         $time, o_payload_byte, o_byte_valid, o_is_text, o_frame_last,
                         o_status);
                mismatches++;
            end else begin
                want = deframed_q.pop_front();
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, o_byte_valid});
                check_field("is_text", {7'd0, want.is_text}, {7'd0, o_is_text});
                check_field("frame_last", {7'd0, want.frame_last}, {7'd0, o_frame_last});
                check_field("status", {5'd0, want.status}, {5'd0, o_status});
            end
            if (o_status == ST_OK) begin
                if (o_byte_valid) begin
                    seen_bytes++;
                end else begin
                    seen_marks++;
                end
            end else if (o_status == ST_CLOSED) begin
                seen_closes++;
            end else begin
                seen_errors++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Timed out after %0d cycles with %0d results still owed.",
                     cycles, deframed_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // The receiver draws a random stall for each result it takes. In calm stretches it
    // draws no stall at all. The long hold-off is counted here, in this process, and the
    // sender keeps offering requests throughout it.
    initial begin : receiver
        int unsigned gap;
        int unsigned hold_left;
        gap         = 0;
        hold_left   = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = LongHold;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (gap != 0) begin
                gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                out_draws++;
                if (out_draws % 64 == 0) begin
                    out_calm = ($urandom_range(0, 3) == 0);
                end
                gap = out_calm ? 0 : $urandom_range(0, 8);
            end
        end
    end

    initial begin : stimulus
        logic [15:0] limits[6];
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_kind            <= KindByte;
        i_stream_byte     <= 8'h00;
        i_cfg_valid       <= 1'b0;
        i_cfg_max_payload <= 16'd0;
        restart_parser();
        cfg_limit = MaxPayloadReset;

        // The table starts with a restart request, then an empty text frame and a
        // single-byte binary frame that unmasks to zero. Four header errors follow. After the
        // first error, a stray byte checks that nothing comes out while the block is halted.
        directed_rows = '{
            '{KindRestart, 8'hFF, 1'b0, NoResult},
            '{KindByte,    8'h81, 1'b0, NoResult},
            '{KindByte,    8'h80, 1'b0, NoResult},
            '{KindByte,    8'h00, 1'b0, NoResult},
            '{KindByte,    8'hFF, 1'b0, NoResult},
            '{KindByte,    8'h00, 1'b0, NoResult},
            '{KindByte,    8'hFF, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, ST_OK}},
            '{KindByte,    8'h82, 1'b0, NoResult},
            '{KindByte,    8'h81, 1'b0, NoResult},
            '{KindByte,    8'hFF, 1'b0, NoResult},
            '{KindByte,    8'h12, 1'b0, NoResult},
            '{KindByte,    8'h34, 1'b0, NoResult},
            '{KindByte,    8'h56, 1'b0, NoResult},
            '{KindByte,    8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b1, ST_OK}},
            '{KindByte,    8'hF1, 1'b0, NoResult},
            '{KindByte,    8'h80, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, ST_RESERVED}},
            '{KindByte,    8'h00, 1'b0, NoResult},
            '{KindRestart, 8'h00, 1'b0, NoResult},
            '{KindByte,    8'h08, 1'b0, NoResult},
            '{KindByte,    8'h80, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, ST_CTRL_FRAG}},
            '{KindRestart, 8'hA5, 1'b0, NoResult},
            '{KindByte,    8'h89, 1'b0, NoResult},
            '{KindByte,    8'hFE, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, ST_CTRL_LONG}},
            '{KindRestart, 8'h5A, 1'b0, NoResult},
            '{KindByte,    8'h80, 1'b0, NoResult},
            '{KindByte,    8'hFF, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, ST_CONTINUATION}},
            '{KindRestart, 8'h00, 1'b0, NoResult}
        };
        // The first phase runs with the reset limit. The later phases cover the extremes,
        // the points on either side of the short length form, and one random limit.
        limits    = '{MaxPayloadReset, 16'd0, 16'hFFFF, 16'd130, 16'd125, 16'd0};
        limits[5] = 16'($urandom_range(126, 600));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DirectedRows; i++) begin
            push_request(directed_rows[i].kind, directed_rows[i].data,
                         directed_rows[i].given, directed_rows[i].want);
        end

        // The block must fill up and stall its input while the receiver holds off.
        hold_off_req = 1'b1;

        for (int p = 0; p < 6; p++) begin
            int unsigned phase_start;
            if (p != 0) begin
                settle();
                write_limit(limits[p]);
            end
            phase_start = useful_requests;
            while (useful_requests - phase_start < PhaseItems) random_frame();
        end
        settle();

        $display("Ran %0d requests under %0d max_payload settings, from 0 up to 65535.",
                 sent_requests, limits_written + 1);
        $display("Checked %0d payload bytes, %0d empty-frame marks, %0d closes, %0d errors.",
                 seen_bytes, seen_marks, seen_closes, seen_errors);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wsfd_pkg.sv
rtl/wsfd_in_stage.sv
rtl/wsfd_parser.sv
rtl/wsfd_out_stage.sv
rtl/websocket_frame_deframer.sv
test/websocket_frame_deframer_tb.sv
